// ----- rtl/prime_counter_trial_division_defines.svh -----
// ----------------------------------------------------------------------------
// Prime counter assertion macros
// Assertion helpers for the trial-division prime counter.
// ----------------------------------------------------------------------------
`ifndef PRIME_COUNTER_TRIAL_DIVISION_DEFINES_SVH
`define PRIME_COUNTER_TRIAL_DIVISION_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PCTD_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define PCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PCTD_ASSERT_IMPL(lbl, ante, cons, msg)
`define PCTD_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- rtl/pctd_pkg.sv -----
// ----------------------------------------------------------------------------
// pctd_pkg
// Types and constants shared by the prime counter controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pctd_pkg;

    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 16;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned MAG_W   = VALUE_W - 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [DIV_W-1:0]   DIV_FIRST = 16'd2;
    localparam logic [VALUE_W-1:0] SQ_FIRST  = 32'd4;

    // controller states, one-hot
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_CHECK  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input item, reset divisor
        logic div_start;  // start remainder of value by divisor
        logic step;       // advance divisor and its square
        logic res_en;     // record primality verdict
        logic res_prime;
        logic out_load;   // move result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic low_val;    // value is negative, zero or one
        logic sq_gt;      // divisor squared exceeds value
        logic rem_done;
        logic rem_zero;
        logic out_full;
    } sts_t;

endpackage

// ----- rtl/pctd_rem.sv -----
// ----------------------------------------------------------------------------
// pctd_rem
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pctd_rem
    import pctd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [MAG_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic             rem_zero
);

    localparam int unsigned CNT_W = $clog2(MAG_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [MAG_W-1:0] sh_reg, sh_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W:0]   trial;

    // shift in next dividend bit and subtract when it fits
    always_comb begin
        trial     = {rem_reg, sh_reg[MAG_W-1]};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MAG_W - 1);
            sh_next   = dividend;
            rem_next  = '0;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = DIV_W'(trial - {1'b0, divisor});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            sh_next = {sh_reg[MAG_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign rem_zero = (rem_reg == '0);

endmodule

// ----- rtl/pctd_dp.sv -----
// ----------------------------------------------------------------------------
// pctd_dp
// Datapath: item registers, divisor and square, running count, output stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "prime_counter_trial_division_defines.svh"

module pctd_dp
    import pctd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output sts_t               sts,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_prime,
    output logic [COUNT_W-1:0] m_prime_count,
    output logic               m_set_done
);

    logic [VALUE_W-1:0] value_reg;
    logic               last_reg;
    logic [DIV_W-1:0]   div_reg;
    logic [VALUE_W-1:0] sq_reg;
    logic               prime_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] count_upd;
    logic               m_valid_reg, m_valid_next;
    logic               m_is_prime_reg;
    logic [COUNT_W-1:0] m_prime_count_reg;
    logic               m_set_done_reg;
    logic               rem_done;
    logic               rem_zero;

    // remainder of value by current divisor
    pctd_rem u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (value_reg[MAG_W-1:0]),
        .divisor  (div_reg),
        .done     (rem_done),
        .rem_zero (rem_zero)
    );

    // reset divisor on load; advance divisor, square grows by 2d+1
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg <= DIV_FIRST;
            sq_reg  <= SQ_FIRST;
        end else if (cmd.load) begin
            div_reg <= DIV_FIRST;
            sq_reg  <= SQ_FIRST;
        end else if (cmd.step) begin
            div_reg <= div_reg + 1'b1;
            sq_reg  <= sq_reg + VALUE_W'({div_reg, 1'b1});
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_value;
            last_reg  <= s_last;
        end
        if (cmd.res_en) begin
            prime_reg <= cmd.res_prime;
        end
    end

    // update saturating count, clear after last item
    always_comb begin
        count_upd    = count_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        if (prime_reg && count_reg != COUNT_MAX) begin
            count_upd = count_reg + 1'b1;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
            count_next   = last_reg ? '0 : count_upd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_is_prime_reg    <= prime_reg;
            m_prime_count_reg <= count_upd;
            m_set_done_reg    <= last_reg;
        end
    end

    assign sts.low_val  = value_reg[VALUE_W-1] || (value_reg[MAG_W-1:0] <= MAG_W'(1));
    assign sts.sq_gt    = sq_reg > value_reg;
    assign sts.rem_done = rem_done;
    assign sts.rem_zero = rem_zero;
    assign sts.out_full = m_valid_reg;

    assign m_valid       = m_valid_reg;
    assign m_is_prime    = m_is_prime_reg;
    assign m_prime_count = m_prime_count_reg;
    assign m_set_done    = m_set_done_reg;

    `PCTD_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !m_valid_reg, "result overwritten")
    `PCTD_ASSERT_IMPL(a_div_in_range, rem_done, sq_reg <= value_reg, "divisor past square root")
    `PCTD_ASSERT_NEXT(a_cnt_up, cmd.out_load && !last_reg, count_reg >= $past(count_reg), "count fell")

endmodule

// ----- rtl/pctd_ctrl.sv -----
// ----------------------------------------------------------------------------
// pctd_ctrl
// Controller: sequences bound check, trial divisions and result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pctd_ctrl
    import pctd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.low_val) begin
                    cmd.res_en    = 1'b1;
                    cmd.res_prime = 1'b0;
                    state_next    = ST_FINISH;
                end else if (sts.sq_gt) begin
                    cmd.res_en    = 1'b1;
                    cmd.res_prime = 1'b1;
                    state_next    = ST_FINISH;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                if (sts.rem_done) begin
                    if (sts.rem_zero) begin
                        cmd.res_en    = 1'b1;
                        cmd.res_prime = 1'b0;
                        state_next    = ST_FINISH;
                    end else begin
                        cmd.step   = 1'b1;
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_FINISH: begin
                if (!sts.out_full) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- rtl/prime_counter_trial_division.sv -----
// ----------------------------------------------------------------------------
// prime_counter_trial_division
// Trial-division primality test with a per-set saturating prime count.
// ----------------------------------------------------------------------------
// Channel  Dir  Ports                                        Transfer
// s_       in   s_value[31:0] s_last                         s_valid & s_ready
// m_       out  m_is_prime m_prime_count[15:0] m_set_done    m_valid & m_ready
//
// Flow: one item at a time. Values below two or negative go from the bound
// check straight to the result; otherwise each trial divisor d passes through
// the bit-serial remainder unit (a check-and-start state, 31 dividend bits,
// a result state), for d = 2 .. floor(sqrt(v)) until a remainder is zero.
// Reset: synchronous, active low; clears the running count and output valid.
// Stalls: a result waits in the output register while the next item is taken
// and tested; it blocks only the hand-off of the following result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_counter_trial_division
    import pctd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [VALUE_W-1:0] s_value,
    input  logic               s_last,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_is_prime,
    output logic [COUNT_W-1:0] m_prime_count,
    output logic               m_set_done
);

    cmd_t cmd;
    sts_t sts;

    // sequencing
    pctd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // arithmetic and storage
    pctd_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .s_value       (s_value),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_is_prime    (m_is_prime),
        .m_prime_count (m_prime_count),
        .m_set_done    (m_set_done)
    );

endmodule
